// ----- design/gclt_pkg.sv -----
package gclt_pkg;

  // Default geometry of the fixed-point coordinates.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_DIGITS_DEF = 3;

  // Fixed widths of the ports and of the number accumulator.
  localparam int CH_W       = 8;
  localparam int MAG_W      = 64;
  localparam int MAG_CAP_B  = 60;
  localparam int FEED_CFG_W = 31;
  localparam int MS_W       = 31;
  localparam int TIME_W     = 27;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register map: one register, selected by the word index of paddr.
  localparam logic REG_INITIAL_FEED = 1'b0;

  localparam logic [FEED_CFG_W-1:0] INIT_FEED = 31'd7500000;
  localparam logic [TIME_W-1:0]     DAY_MS    = 27'd86400000;
  localparam logic [MS_W-1:0]       MS_SAT    = 31'h7FFFFFFF;
  localparam int                    MOVE_SCALE_W = 16;
  localparam logic [MOVE_SCALE_W-1:0] MOVE_SCALE = 16'd60000;

  // Character codes.
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_POINT  = 8'h2E;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_CASE   = 8'h20;
  localparam logic [CH_W-1:0] CH_B      = 8'h42;
  localparam logic [CH_W-1:0] CH_D      = 8'h44;
  localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CH_W-1:0] CH_G      = 8'h47;
  localparam logic [CH_W-1:0] CH_M      = 8'h4D;
  localparam logic [CH_W-1:0] CH_X      = 8'h58;
  localparam logic [CH_W-1:0] CH_Y      = 8'h59;
  localparam logic [CH_W-1:0] CH_Z      = 8'h5A;
  localparam logic [CH_W-1:0] CH_S      = 8'h53;
  localparam logic [CH_W-1:0] CH_F      = 8'h46;

  // Axis codes.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    TK_NONE, TK_G, TK_M, TK_X, TK_Y, TK_Z, TK_S, TK_F
  } token_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_CHK, S_SQ, S_ROOT, S_NMUL, S_DIV, S_MOD, S_POS, S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept_char;
    logic       accept_eol;
    logic       fin_step;
    logic       fin_commit;
    logic       set_bad;
    logic       mul_clr;
    logic       mul_load_sq;
    logic [1:0] sq_axis;
    logic       mul_load_n;
    logic       mul_step;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       div_load;
    logic       div_step;
    logic       sat;
    logic       mod_step;
    logic       end_line;
    logic       out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_finish;
    logic skipped;
    logic scale_done;
    logic feed_bad;
    logic mul_done;
    logic iter_done;
    logic mod_done;
  } dp_stat_t;

endpackage

// ----- design/gclt_ctrl.sv -----
module gclt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gclt_pkg::dp_cmd_t  cmd_o,
  input  gclt_pkg::dp_stat_t stat_i
);
  import gclt_pkg::*;

  state_e     state_q, state_d;
  logic       eol_q, eol_d;
  logic [1:0] axis_q, axis_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i) begin
            state_d = stat_i.skipped ? S_POS : S_FIN;
          end else if (stat_i.need_finish) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.scale_done) begin
          state_d = eol_q ? S_CHK : S_IDLE;
        end
      end
      S_CHK:  state_d = stat_i.feed_bad ? S_POS : S_SQ;
      S_SQ: begin
        if (stat_i.mul_done && axis_q == AX_Z) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: if (stat_i.iter_done) begin state_d = S_NMUL; end
      S_NMUL: if (stat_i.mul_done) begin state_d = S_DIV; end
      S_DIV:  if (stat_i.iter_done) begin state_d = S_MOD; end
      S_MOD:  if (stat_i.mod_done) begin state_d = S_POS; end
      S_POS:  state_d = S_OUT;
      S_OUT:  if (out_free) begin state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands and controller registers.
  always_comb begin
    cmd_o       = '0;
    eol_d       = eol_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          eol_d = kind_i;
          if (kind_i) begin
            cmd_o.accept_eol = 1'b1;
          end else begin
            cmd_o.accept_char = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (stat_i.scale_done) begin
          cmd_o.fin_commit = 1'b1;
        end else begin
          cmd_o.fin_step = 1'b1;
        end
      end
      S_CHK: begin
        if (stat_i.feed_bad) begin
          cmd_o.set_bad = 1'b1;
        end else begin
          cmd_o.mul_clr     = 1'b1;
          cmd_o.mul_load_sq = 1'b1;
          cmd_o.sq_axis     = AX_X;
          axis_d            = AX_X;
        end
      end
      S_SQ: begin
        if (stat_i.mul_done) begin
          if (axis_q == AX_Z) begin
            cmd_o.sqrt_load = 1'b1;
          end else begin
            cmd_o.mul_load_sq = 1'b1;
            cmd_o.sq_axis     = axis_q + 2'd1;
            axis_d            = axis_q + 2'd1;
          end
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_ROOT: begin
        if (stat_i.iter_done) begin
          cmd_o.mul_clr    = 1'b1;
          cmd_o.mul_load_n = 1'b1;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      S_NMUL: begin
        if (stat_i.mul_done) begin
          cmd_o.div_load = 1'b1;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat_i.iter_done) begin
          cmd_o.sat = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_MOD: begin
        if (!stat_i.mod_done) begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_POS: cmd_o.end_line = 1'b1;
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          eol_d          = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eol_q       <= 1'b0;
      axis_q      <= AX_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eol_q       <= eol_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/gclt_dpath.sv -----
module gclt_dpath #(
  parameter int COORD_WIDTH = gclt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_DIGITS = gclt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gclt_pkg::CH_W-1:0]       ch_i,
  input  logic                            cfg_we_i,
  input  logic [gclt_pkg::FEED_CFG_W-1:0] cfg_feed_i,
  input  gclt_pkg::dp_cmd_t               cmd_i,
  output gclt_pkg::dp_stat_t              stat_o,
  output logic [gclt_pkg::TIME_W-1:0]     elapsed_ms_o,
  output logic [gclt_pkg::MS_W-1:0]       line_ms_o,
  output logic                            feed_invalid_o,
  output logic                            line_skipped_o
);
  import gclt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = 2 * CW + 2;
  localparam int RW    = CW + 1;
  localparam int NW    = RW + MOVE_SCALE_W;
  localparam int FW    = $clog2(FRAC_DIGITS + 2);
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [MAG_W-1:0] CMIN_MAG = 64'd1 << (CW - 1);
  localparam logic [MAG_W-1:0] CMAX64   = CMIN_MAG - 64'd1;
  localparam logic [MAG_W-1:0] FEED_R64 =
      ({33'd0, INIT_FEED} > CMAX64) ? CMAX64 : {33'd0, INIT_FEED};
  localparam logic signed [CW-1:0] CMAX_C = CMAX64[CW-1:0];
  localparam logic signed [CW-1:0] CMIN_C = CMIN_MAG[CW-1:0];
  localparam logic [FW-1:0] FRAC_LIM = FW'(FRAC_DIGITS);

  function automatic token_e token_of(input logic [CH_W-1:0] c);
    token_e t;
    unique case (c)
      CH_G:    t = TK_G;
      CH_M:    t = TK_M;
      CH_X:    t = TK_X;
      CH_Y:    t = TK_Y;
      CH_Z:    t = TK_Z;
      CH_S:    t = TK_S;
      CH_F:    t = TK_F;
      default: t = TK_NONE;
    endcase
    return t;
  endfunction

  // Architectural state.
  logic signed [CW-1:0] last_q [3];
  logic signed [CW-1:0] last_d [3];
  logic signed [CW-1:0] line_q [3];
  logic signed [CW-1:0] line_d [3];
  logic signed [CW-1:0] feed_q, feed_d;
  logic                 rel_q, rel_d;
  logic [TIME_W-1:0]    total_q, total_d;
  token_e               tok_q, tok_d, pend_tok_q, pend_tok_d;
  logic [MAG_W-1:0]     mag_q, mag_d;
  logic [FW-1:0]        frac_q, frac_d;
  logic                 neg_q, neg_d, point_q, point_d, digit_q, digit_d, err_q, err_d;
  logic                 first_q, first_d, comment_q, comment_d, skip_q, skip_d;

  // Arithmetic work registers.
  logic [PW-1:0]        mul_a_q, mul_a_d, acc_q, acc_d, rad_q, rad_d;
  logic [CW-1:0]        mul_b_q, mul_b_d;
  logic [RW+1:0]        rem_q, rem_d;
  logic [RW-1:0]        root_q, root_d;
  logic [NW-1:0]        dvd_q, dvd_d;
  logic [CW-1:0]        drem_q, drem_d, dvs_q, dvs_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MS_W-1:0]      ms_q, ms_d, mod_q, mod_d;
  logic                 bad_q, bad_d, rskip_q, rskip_d;
  logic [TIME_W-1:0]    out_el_q;
  logic [MS_W-1:0]      out_ms_q;
  logic                 out_bad_q, out_skip_q;

  // Character classification.
  logic [CH_W-1:0]      c;
  logic                 is_digit, is_num, active, is_skipch;
  logic [MAG_W-1:0]     mag_x10, mag_add;
  logic                 mag_small, tok_num, g_ok;
  logic signed [CW-1:0] acc_val;

  always_comb begin
    c = ch_i;
    if (ch_i >= CH_LOW_A && ch_i <= CH_LOW_Z) begin
      c = ch_i - CH_CASE;
    end
  end

  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_num    = is_digit || c == CH_MINUS || c == CH_POINT;
  assign active    = !comment_q && !skip_q;
  assign is_skipch = first_q && (c == CH_B || c == CH_D || c == CH_DOLLAR);
  assign mag_small = (mag_q[MAG_W-1:MAG_CAP_B] == '0);
  assign mag_x10   = (mag_q << 3) + (mag_q << 1);
  assign mag_add   = mag_x10 + MAG_W'(c - CH_ZERO);
  assign tok_num   = (tok_q == TK_X) || (tok_q == TK_Y) || (tok_q == TK_Z) ||
                     (tok_q == TK_F);
  assign g_ok      = digit_q && !point_q && !neg_q && !err_q &&
                     (mag_q == 64'd90 || mag_q == 64'd91);

  // Decimal value of the finished token, saturated to the coordinate range.
  always_comb begin
    if (err_q || !digit_q) begin
      acc_val = '0;
    end else if (neg_q) begin
      acc_val = (mag_q > CMIN_MAG) ? CMIN_C : -$signed(mag_q[CW-1:0]);
    end else begin
      acc_val = (mag_q > CMAX64) ? CMAX_C : $signed(mag_q[CW-1:0]);
    end
  end

  // Move distance operand for the selected axis.
  logic signed [CW-1:0] sel_line, sel_last;
  logic signed [CW:0]   diff;
  logic [CW:0]          diff_abs;
  logic [CW-1:0]        absd;

  assign sel_line = line_q[cmd_i.sq_axis];
  assign sel_last = last_q[cmd_i.sq_axis];
  assign diff     = rel_q ? (CW+1)'(sel_line) : (CW+1)'(sel_line) - (CW+1)'(sel_last);
  assign diff_abs = diff[CW] ? -diff : diff;
  assign absd     = diff_abs[CW-1:0];

  // Sum of relative position and move, clamped per axis.
  logic signed [CW:0]   psum [3];
  logic signed [CW-1:0] pclamp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = (CW+1)'(last_q[i]) + (CW+1)'(line_q[i]);
      if (psum[i][CW] != psum[i][CW-1]) begin
        pclamp[i] = psum[i][CW] ? CMIN_C : CMAX_C;
      end else begin
        pclamp[i] = psum[i][CW-1:0];
      end
    end
  end

  // Square root and division step values.
  logic [RW+3:0] sq_rem_t, sq_trial, sq_diff;
  logic [CW:0]   dv_t, dv_diff;
  logic          dv_bit;
  logic [TIME_W:0] tot_sum;

  assign sq_rem_t = {rem_q, rad_q[PW-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_diff  = sq_rem_t - sq_trial;
  assign dv_t     = {drem_q, dvd_q[NW-1]};
  assign dv_diff  = dv_t - {1'b0, dvs_q};
  assign dv_bit   = (dv_t >= {1'b0, dvs_q});
  assign tot_sum  = {1'b0, total_q} + {1'b0, mod_q[TIME_W-1:0]};

  // Next-state logic of the datapath.
  always_comb begin
    last_d     = last_q;
    line_d     = line_q;
    feed_d     = feed_q;
    rel_d      = rel_q;
    total_d    = total_q;
    tok_d      = tok_q;
    pend_tok_d = pend_tok_q;
    mag_d      = mag_q;
    frac_d     = frac_q;
    neg_d      = neg_q;
    point_d    = point_q;
    digit_d    = digit_q;
    err_d      = err_q;
    first_d    = first_q;
    comment_d  = comment_q;
    skip_d     = skip_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    acc_d      = acc_q;
    rad_d      = rad_q;
    rem_d      = rem_q;
    root_d     = root_q;
    dvd_d      = dvd_q;
    drem_d     = drem_q;
    dvs_d      = dvs_q;
    cnt_d      = cnt_q;
    ms_d       = ms_q;
    mod_d      = mod_q;
    bad_d      = bad_q;
    rskip_d    = rskip_q;

    // One text character.
    if (cmd_i.accept_char && active) begin
      first_d = 1'b0;
      if (is_skipch) begin
        skip_d = 1'b1;
      end else if (c == CH_SEMI) begin
        comment_d = 1'b1;
      end else if (is_num) begin
        if (tok_q != TK_NONE) begin
          if (c == CH_MINUS) begin
            if (neg_q || digit_q || point_q) err_d = 1'b1;
            else neg_d = 1'b1;
          end else if (c == CH_POINT) begin
            if (point_q) err_d = 1'b1;
            else point_d = 1'b1;
          end else begin
            digit_d = 1'b1;
            if (!point_q || frac_q < FRAC_LIM) begin
              if (mag_small) mag_d = mag_add;
              if (point_q) frac_d = frac_q + 1'b1;
            end
          end
        end
      end else begin
        pend_tok_d = token_of(c);
      end
    end

    // End of line: clear the result of the previous line.
    if (cmd_i.accept_eol) begin
      pend_tok_d = TK_NONE;
      ms_d       = '0;
      mod_d      = '0;
      bad_d      = 1'b0;
    end

    // Scale missing fraction digits.
    if (cmd_i.fin_step) begin
      if (mag_small) mag_d = mag_x10;
      frac_d = frac_q + 1'b1;
    end

    // Apply the finished token.
    if (cmd_i.fin_commit) begin
      case (tok_q)
        TK_G: begin
          if (g_ok) begin
            rel_d = mag_q[0];
            for (int i = 0; i < 3; i++) begin
              line_d[i] = mag_q[0] ? '0 : last_q[i];
            end
          end
        end
        TK_X:    line_d[AX_X] = acc_val;
        TK_Y:    line_d[AX_Y] = acc_val;
        TK_Z:    line_d[AX_Z] = acc_val;
        TK_F:    feed_d = acc_val;
        default: ;
      endcase
      tok_d   = pend_tok_q;
      mag_d   = '0;
      frac_d  = '0;
      neg_d   = 1'b0;
      point_d = 1'b0;
      digit_d = 1'b0;
      err_d   = 1'b0;
    end

    if (cmd_i.set_bad) bad_d = 1'b1;

    // Shift-add multiplier.
    if (cmd_i.mul_clr) acc_d = '0;
    if (cmd_i.mul_load_sq) begin
      mul_a_d = PW'(absd);
      mul_b_d = absd;
    end
    if (cmd_i.mul_load_n) begin
      mul_a_d = PW'(root_q);
      mul_b_d = CW'(MOVE_SCALE);
    end
    if (cmd_i.mul_step) begin
      if (mul_b_q[0]) acc_d = acc_q + mul_a_q;
      mul_a_d = mul_a_q << 1;
      mul_b_d = mul_b_q >> 1;
    end

    // Integer square root, two radicand bits per step.
    if (cmd_i.sqrt_load) begin
      rad_d  = acc_q;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(RW);
    end
    if (cmd_i.sqrt_step) begin
      if (sq_rem_t >= sq_trial) begin
        rem_d  = sq_diff[RW+1:0];
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = sq_rem_t[RW+1:0];
        root_d = {root_q[RW-2:0], 1'b0};
      end
      rad_d = rad_q << 2;
      cnt_d = cnt_q - 1'b1;
    end

    // Restoring division by the feed rate.
    if (cmd_i.div_load) begin
      dvd_d  = acc_q[NW-1:0];
      drem_d = '0;
      dvs_d  = feed_q;
      cnt_d  = CNT_W'(NW);
    end
    if (cmd_i.div_step) begin
      drem_d = dv_bit ? dv_diff[CW-1:0] : dv_t[CW-1:0];
      dvd_d  = {dvd_q[NW-2:0], dv_bit};
      cnt_d  = cnt_q - 1'b1;
    end

    // Saturate the line time, then reduce it modulo one day.
    if (cmd_i.sat) begin
      ms_d  = (dvd_q[NW-1:MS_W] != '0) ? MS_SAT : dvd_q[MS_W-1:0];
      mod_d = (dvd_q[NW-1:MS_W] != '0) ? MS_SAT : dvd_q[MS_W-1:0];
    end
    if (cmd_i.mod_step) begin
      mod_d = mod_q - MS_W'(DAY_MS);
    end

    // Close the line.
    if (cmd_i.end_line) begin
      if (!skip_q) begin
        for (int i = 0; i < 3; i++) begin
          last_d[i] = rel_q ? pclamp[i] : line_q[i];
        end
        total_d = (tot_sum >= {1'b0, DAY_MS}) ? TIME_W'(tot_sum - {1'b0, DAY_MS})
                                              : tot_sum[TIME_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        line_d[i] = rel_q ? '0 : last_d[i];
      end
      rskip_d   = skip_q;
      tok_d     = TK_NONE;
      mag_d     = '0;
      frac_d    = '0;
      neg_d     = 1'b0;
      point_d   = 1'b0;
      digit_d   = 1'b0;
      err_d     = 1'b0;
      first_d   = 1'b1;
      comment_d = 1'b0;
      skip_d    = 1'b0;
    end

    // A configuration write reloads the feed.
    if (cfg_we_i) begin
      feed_d = ({33'd0, cfg_feed_i} > CMAX64) ? CMAX_C : $signed(CW'(cfg_feed_i));
    end
  end

  // Status.
  assign stat_o.need_finish = active && !is_skipch && c != CH_SEMI && !is_num;
  assign stat_o.skipped     = skip_q;
  assign stat_o.scale_done  = !tok_num || err_q || !digit_q || frac_q == FRAC_LIM;
  assign stat_o.feed_bad    = feed_q[CW-1] || feed_q == '0;
  assign stat_o.mul_done    = (mul_b_q == '0);
  assign stat_o.iter_done   = (cnt_q == '0);
  assign stat_o.mod_done    = (mod_q < MS_W'(DAY_MS));

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        last_q[i] <= '0;
        line_q[i] <= '0;
      end
      feed_q     <= FEED_R64[CW-1:0];
      rel_q      <= 1'b0;
      total_q    <= '0;
      tok_q      <= TK_NONE;
      pend_tok_q <= TK_NONE;
      mag_q      <= '0;
      frac_q     <= '0;
      neg_q      <= 1'b0;
      point_q    <= 1'b0;
      digit_q    <= 1'b0;
      err_q      <= 1'b0;
      first_q    <= 1'b1;
      comment_q  <= 1'b0;
      skip_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      last_q     <= last_d;
      line_q     <= line_d;
      feed_q     <= feed_d;
      rel_q      <= rel_d;
      total_q    <= total_d;
      tok_q      <= tok_d;
      pend_tok_q <= pend_tok_d;
      mag_q      <= mag_d;
      frac_q     <= frac_d;
      neg_q      <= neg_d;
      point_q    <= point_d;
      digit_q    <= digit_d;
      err_q      <= err_d;
      first_q    <= first_d;
      comment_q  <= comment_d;
      skip_q     <= skip_d;
      cnt_q      <= cnt_d;
    end
  end

  // Work and result registers.
  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    acc_q   <= acc_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    dvd_q   <= dvd_d;
    drem_q  <= drem_d;
    dvs_q   <= dvs_d;
    ms_q    <= ms_d;
    mod_q   <= mod_d;
    bad_q   <= bad_d;
    rskip_q <= rskip_d;
    if (cmd_i.out_load) begin
      out_el_q   <= total_q;
      out_ms_q   <= ms_q;
      out_bad_q  <= bad_q;
      out_skip_q <= rskip_q;
    end
  end

  assign elapsed_ms_o   = out_el_q;
  assign line_ms_o      = out_ms_q;
  assign feed_invalid_o = out_bad_q;
  assign line_skipped_o = out_skip_q;

endmodule

// ----- design/gcode_line_move_timestamper.sv -----
// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+----------------------------------------
// in      | input     | in_valid_i/in_ready_o | kind_i, ch_i
// out     | output    | out_valid_o/out_ready_i | elapsed_ms_o, line_ms_o, flags
// apb     | input     | psel/penable/pready   | initial_feed at byte address 0
//
// A text character is taken in the idle state; a character that ends a number token
// is followed by decimal scaling for missing fraction digits and a step to apply it.
// An end-of-line word is accepted, then the open token is closed, the feed is
// checked, the three squares are formed by shift-add, the square root is taken,
// the root is scaled by 60000, divided by the feed and wrapped to one day, and
// the line is closed and the result loaded; a bad feed skips the arithmetic,
// and a skipped line goes straight to closing the line.
// Reset is asynchronous and active low; the block is ready right after it.
// A finished result waits in the output register while text words are taken;
// the next line's result waits until that register is free.
module gcode_line_move_timestamper #(
  parameter int COORD_WIDTH = gclt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_DIGITS = gclt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [gclt_pkg::CH_W-1:0]    ch_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gclt_pkg::TIME_W-1:0]  elapsed_ms_o,
  output logic [gclt_pkg::MS_W-1:0]    line_ms_o,
  output logic                         feed_invalid_o,
  output logic                         line_skipped_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gclt_pkg::PADDR_W-1:0] paddr,
  input  logic [gclt_pkg::PDATA_W-1:0] pwdata,
  output logic [gclt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import gclt_pkg::*;

  logic [FEED_CFG_W-1:0] feed_cfg_q;
  logic                  cfg_we;
  logic                  reg_hit;
  dp_cmd_t               cmd;
  dp_stat_t              stat;

  // Register access.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_INITIAL_FEED) && (paddr[1:0] == 2'b00);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {1'b0, feed_cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_cfg_q <= INIT_FEED;
    end else if (cfg_we) begin
      feed_cfg_q <= pwdata[FEED_CFG_W-1:0];
    end
  end

  gclt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  gclt_dpath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ch_i           (ch_i),
    .cfg_we_i       (cfg_we),
    .cfg_feed_i     (pwdata[FEED_CFG_W-1:0]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .elapsed_ms_o   (elapsed_ms_o),
    .line_ms_o      (line_ms_o),
    .feed_invalid_o (feed_invalid_o),
    .line_skipped_o (line_skipped_o)
  );

  // The running total always stays below one day.
  a_total_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> elapsed_ms_o < DAY_MS)
    else $error("elapsed time outside one day");

  // A skipped line adds no time and never reports a bad feed.
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_skipped_o |-> line_ms_o == '0 && !feed_invalid_o)
    else $error("skipped line reported time or bad feed");

  // A bad feed adds no time.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && feed_invalid_o |-> line_ms_o == '0)
    else $error("bad feed line reported time");

  // An end-of-line word always occupies the block for the next cycle.
  a_eol_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i |=> !in_ready_o)
    else $error("block ready right after an end of line");

endmodule

// ----- dv/gclt_checker.sv -----
`timescale 1ns / 1ps

// Watches the text, result and register channels of the timestamper, keeps a
// cycle-free model of its parser and timing math, and compares every result.
module gclt_checker
  import gclt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              kind_i,
  input  logic [CH_W-1:0]   ch_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [TIME_W-1:0] elapsed_ms_i,
  input  logic [MS_W-1:0]   line_ms_i,
  input  logic              feed_invalid_i,
  input  logic              line_skipped_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output int                errors_o,
  output int                pending_o
);

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -CMAX - 1;
  localparam longint unsigned MAGCAP = 64'd1 << 60;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [MS_W-1:0]   line_ms;
    logic              bad;
    logic              skip;
  } line_result_t;

  line_result_t line_results_q[$];

  // Model state of the parser and the motion totals.
  longint           pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, feed;
  bit               rel_mode;
  int unsigned      total_ms;
  token_e           tok;
  longint unsigned  mag;
  int               frac;
  bit               neg, pt, dig, nerr;
  bit               first_ch, in_cmt, skipping;

  function automatic longint clamp(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function void clear_number();
    mag = 0; frac = 0; neg = 0; pt = 0; dig = 0; nerr = 0;
  endfunction

  function void load_defaults();
    tgt_x = rel_mode ? 0 : pos_x;
    tgt_y = rel_mode ? 0 : pos_y;
    tgt_z = rel_mode ? 0 : pos_z;
  endfunction

  function longint number_value();
    longint unsigned m;
    m = mag;
    if (nerr || !dig) return 0;
    for (int i = frac; i < FRAC_DIGITS_DEF; i++)
      if (m < MAGCAP) m = m * 10;
    if (neg) return (m > longint'(CMAX) + 1) ? CMIN : -longint'(m);
    return (m > CMAX) ? CMAX : longint'(m);
  endfunction

  // Closes the open token and applies its value.
  function void close_token();
    case (tok)
      TK_G: if (dig && !pt && !neg && !nerr && (mag == 90 || mag == 91)) begin
        rel_mode = (mag == 91);
        load_defaults();
      end
      TK_X: tgt_x = number_value();
      TK_Y: tgt_y = number_value();
      TK_Z: tgt_z = number_value();
      TK_F: feed = number_value();
      default: ;
    endcase
    tok = TK_NONE;
    clear_number();
  endfunction

  function void take_text(logic [CH_W-1:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CH_CASE;
    if (in_cmt || skipping) return;
    if (first_ch) begin
      first_ch = 0;
      if (c == CH_B || c == CH_D || c == CH_DOLLAR) begin
        skipping = 1;
        return;
      end
    end
    if (c == CH_SEMI) begin
      in_cmt = 1;
      return;
    end
    if (c == CH_MINUS || c == CH_POINT || (c >= CH_ZERO && c <= CH_NINE)) begin
      if (tok != TK_NONE) begin
        if (c == CH_MINUS) begin
          if (neg || dig || pt) nerr = 1; else neg = 1;
        end else if (c == CH_POINT) begin
          if (pt) nerr = 1; else pt = 1;
        end else begin
          dig = 1;
          if (!pt || frac < FRAC_DIGITS_DEF) begin
            if (mag < MAGCAP) mag = mag * 10 + (c - CH_ZERO);
            if (pt) frac++;
          end
        end
      end
      return;
    end
    close_token();
    case (c)
      CH_G: tok = TK_G;
      CH_M: tok = TK_M;
      CH_X: tok = TK_X;
      CH_Y: tok = TK_Y;
      CH_Z: tok = TK_Z;
      CH_S: tok = TK_S;
      CH_F: tok = TK_F;
      default: tok = TK_NONE;
    endcase
  endfunction

  // Works out the move time of the finished line and the new running total.
  function line_result_t finish_line();
    line_result_t r;
    longint d[3];
    longint unsigned a, travel, cand, q, rem, t;
    logic [127:0] sum;
    r = '0;
    r.skip = skipping;
    if (!skipping) begin
      close_token();
      d[0] = rel_mode ? tgt_x : tgt_x - pos_x;
      d[1] = rel_mode ? tgt_y : tgt_y - pos_y;
      d[2] = rel_mode ? tgt_z : tgt_z - pos_z;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        a = d[k] < 0 ? -d[k] : d[k];
        sum = sum + {64'd0, a} * {64'd0, a};
      end
      travel = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = travel | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= sum) travel = cand;
      end
      if (feed <= 0) begin
        r.bad = 1;
      end else begin
        q = travel / feed;
        rem = travel % feed;
        if (q > MS_SAT) r.line_ms = MS_SAT;
        else begin
          t = q * 60000 + (rem * 60000) / feed;
          r.line_ms = t > MS_SAT ? MS_SAT : t[MS_W-1:0];
        end
      end
      if (rel_mode) begin
        pos_x = clamp(pos_x + tgt_x);
        pos_y = clamp(pos_y + tgt_y);
        pos_z = clamp(pos_z + tgt_z);
      end else begin
        pos_x = tgt_x; pos_y = tgt_y; pos_z = tgt_z;
      end
      total_ms = (total_ms + r.line_ms % DAY_MS) % DAY_MS;
    end
    r.elapsed = total_ms[TIME_W-1:0];
    load_defaults();
    tok = TK_NONE;
    clear_number();
    first_ch = 1; in_cmt = 0; skipping = 0;
    return r;
  endfunction

  assign pending_o = line_results_q.size();

  // Predict on each accepted word, then compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t exp_r;
    if (!rst_ni) begin
      pos_x = 0; pos_y = 0; pos_z = 0; tgt_x = 0; tgt_y = 0; tgt_z = 0;
      feed = INIT_FEED; rel_mode = 0; total_ms = 0; tok = TK_NONE;
      clear_number();
      first_ch = 1; in_cmt = 0; skipping = 0;
      line_results_q.delete();
      errors_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[PADDR_W-1:2] == REG_INITIAL_FEED)
        feed = pwdata_i[FEED_CFG_W-1:0];
      if (in_valid_i && in_ready_i) begin
        if (kind_i) line_results_q.push_back(finish_line());
        else take_text(ch_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (line_results_q.size() == 0) begin
          $error("result word with no line pending");
          errors_o++;
        end else begin
          exp_r = line_results_q.pop_front();
          if (elapsed_ms_i !== exp_r.elapsed) begin
            $error("elapsed_ms: expected %0d, got %0d", exp_r.elapsed, elapsed_ms_i);
            errors_o++;
          end
          if (line_ms_i !== exp_r.line_ms) begin
            $error("line_ms: expected %0d, got %0d", exp_r.line_ms, line_ms_i);
            errors_o++;
          end
          if (feed_invalid_i !== exp_r.bad) begin
            $error("feed_invalid: expected %0b, got %0b", exp_r.bad, feed_invalid_i);
            errors_o++;
          end
          if (line_skipped_i !== exp_r.skip) begin
            $error("line_skipped: expected %0b, got %0b", exp_r.skip, line_skipped_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import gclt_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 3000000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic               kind_i = 0;
  logic [CH_W-1:0]    ch_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic [TIME_W-1:0]  elapsed_ms_o;
  logic [MS_W-1:0]    line_ms_o;
  logic               feed_invalid_o;
  logic               line_skipped_o;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int  errors, lines_pending, cycles;
  int  send_idle_pct, recv_stall_pct;
  bit  word_taken;
  int  words_sent;
  logic [CH_W-1:0] text_q[$];

  gcode_line_move_timestamper u_dut (.*);

  gclt_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .ch_i,
    .out_valid_i(out_valid_o), .out_ready_i, .elapsed_ms_i(elapsed_ms_o),
    .line_ms_i(line_ms_o), .feed_invalid_i(feed_invalid_o),
    .line_skipped_i(line_skipped_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .pready_i(pready), .paddr_i(paddr), .pwdata_i(pwdata),
    .errors_o(errors), .pending_o(lines_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Acceptance of the text word, seen at the edge and read at the next fall.
  always @(posedge clk_i) begin
    word_taken <= in_valid_i && in_ready_o;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high after a word so the next one can follow back to back.
  task automatic send_word(input logic kind, input logic [CH_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    ch_i <= c;
    do @(negedge clk_i); while (!word_taken);
    words_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Sends the queued text as one line, then the end-of-line word.
  task automatic send_line();
    while (text_q.size() > 0) send_word(1'b0, text_q.pop_front());
    send_word(1'b1, CH_W'($urandom_range(255)));
  endtask

  task automatic add_number();
    int n;
    if ($urandom_range(9) == 0) begin
      // Deliberately malformed or oversized text.
      case ($urandom_range(3))
        0: add_text("--1");
        1: add_text("1.2.3");
        2: add_text("9999999999999");
        default: add_text("5-");
      endcase
      return;
    end
    if ($urandom_range(2) == 0) add_text("-");
    n = $urandom_range(4);
    for (int i = 0; i <= n; i++) text_q.push_back(CH_ZERO + CH_W'($urandom_range(9)));
    if ($urandom_range(1)) begin
      add_text(".");
      n = $urandom_range(5);
      for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + CH_W'($urandom_range(9)));
    end
  endtask

  task automatic add_random_line();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6) begin
      case ($urandom_range(2))
        0: add_text("B");
        1: add_text("d");
        default: add_text("$");
      endcase
      add_text("X12");
      return;
    end
    if (sel < 14) begin
      // Raw noise bytes.
      repeat ($urandom_range(1, 8)) text_q.push_back(CH_W'($urandom_range(255)));
      return;
    end
    if ($urandom_range(4) == 0) add_text($urandom_range(1) ? "G91 " : "G90 ");
    else if ($urandom_range(4) == 0) add_text("G1 ");
    if ($urandom_range(1)) begin add_text($urandom_range(1) ? "X" : "x"); add_number(); end
    if ($urandom_range(1)) begin add_text($urandom_range(1) ? "Y" : "y"); add_number(); end
    if ($urandom_range(2) == 0) begin add_text("Z"); add_number(); end
    if ($urandom_range(3) == 0) begin add_text($urandom_range(1) ? "F" : "f"); add_number(); end
    if ($urandom_range(5) == 0) add_text(" M3 S1000");
    if ($urandom_range(5) == 0) add_text(" ;X99 end");
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (lines_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_feed(input logic [FEED_CFG_W-1:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= '0;
    pwdata <= {1'b0, value};
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  initial begin
    words_sent = 0;
    send_idle_pct = 9;
    recv_stall_pct = 78;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed lines: extremes, the G, X, Y, Z and F tokens, skips, comments and bad feeds.
    add_text("X1.5Y-2z3"); send_line();
    add_text(";comment"); send_line();
    add_text("B1"); send_line();
    add_text("g91x-.5f0"); send_line();
    add_text("G90X2147483.647F-1"); send_line();
    add_text("X-2147483.648Y--1F1"); send_line();
    send_line();

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: write_feed(31'd1);
        1: write_feed(31'h7FFFFFFF);
        default: write_feed(FEED_CFG_W'($urandom_range(1, 32'h7FFFFFFF)));
      endcase
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
      recv_stall_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
      if (phase == 2) begin
        add_text("G91X2000000Y2000000"); send_line();
        add_text("X2000000"); send_line();
      end
      while (words_sent < 340 * (phase + 1) + 40) begin
        add_random_line();
        send_line();
      end
    end

    wait_idle();
    write_feed(INIT_FEED);
    add_text("G90X0Y0Z0"); send_line();
    add_text("X100Y100"); send_line();
    wait_idle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gclt_pkg.sv
design/gclt_ctrl.sv
design/gclt_dpath.sv
design/gcode_line_move_timestamper.sv
dv/gclt_checker.sv
dv/tb.sv
